@@ hw/rtl/sha256_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 hasher.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

   localparam int WordWidth  = 32;
   localparam int CountWidth = 3;
   localparam int IndexWidth = 3;
   localparam int BlockWords = 16;
   localparam int DigestWords = 8;
   localparam int Rounds = 64;

   typedef logic [WordWidth-1:0] word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_word;    // Write the input word (with padding) into the buffer.
      logic       push_pad;     // Write a padding word into the buffer.
      logic [1:0] pad_kind;     // Which padding word to write.
      logic       start_block;  // Load working variables from the chain value.
      logic       round;        // Run one compression round.
      logic       finish_block; // Add working variables into the chain value.
      logic       shift_digest; // Rotate the chain value towards the output.
      logic       reinit;       // Return chain value and length to their start.
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       block_full;   // The buffer position has wrapped to zero.
      logic [3:0] position;     // Next buffer position.
      logic       last_round;   // The round counter sits on the final round.
   } dp_status_type;

   localparam logic [1:0] PadZero  = 2'd0;
   localparam logic [1:0] PadMark  = 2'd1;
   localparam logic [1:0] PadLenHi = 2'd2;
   localparam logic [1:0] PadLenLo = 2'd3;

   localparam word_type InitHash [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordWidth - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sha256_req_if.sv @@
// Valid/ready channel carrying message words into the hasher.
// Depends on sha256_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none
interface sha256_req_if;
   import sha256_pkg::*;
   logic                  valid;
   logic                  ready;
   word_type              data_word;
   logic [CountWidth-1:0] byte_count;
   logic                  last_word;
   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sha256_rsp_if.sv @@
// Valid/ready channel carrying digest words out of the hasher.
// Depends on sha256_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none
interface sha256_rsp_if;
   import sha256_pkg::*;
   logic                  valid;
   logic                  ready;
   word_type              digest_word;
   logic [IndexWidth-1:0] digest_index;
   logic                  digest_last;
   modport source (output valid, digest_word, digest_index, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sha256_stream_hasher_core.sv @@
// Streaming SHA-256 hasher, top level.
// Channels: req carries big-endian message words with byte_count and last_word;
// rsp carries the eight digest words, index 0 first, digest_last on the eighth.
// Words are taken one per transfer; a word that fills the 16-word block starts a
// compression (load, 64 rounds at one round per cycle, chain update), and no new
// word is accepted until the chain update is done.
// On a last word the block writes padding one word per cycle, runs one or two
// final compressions, then offers the digest words one per cycle while the
// receiver is ready.
// When the receiver stalls, the current digest word is held and no new word is
// accepted until all eight have been transferred; the state then returns to
// the initial hash value and zero length.
// Reset is synchronous and active high; it loads the initial hash value and
// clears the length and block position. No clearing pass is needed.
// Depends on sha256_pkg, sha256_req_if, sha256_rsp_if, sha256_controller and
// sha256_datapath.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_core (
   input  wire logic  clock,
   input  wire logic  reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   import sha256_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   word_type      digest_word;
   logic [IndexWidth-1:0] index;

   sha256_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_count (req.byte_count),
      .req_last  (req.last_word),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_index (index),
      .cmd       (cmd),
      .status    (status)
   );

   sha256_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_word     (req.data_word),
      .in_count    (req.byte_count),
      .in_last     (req.last_word),
      .digest_word (digest_word)
   );

   assign rsp.digest_word  = digest_word;
   assign rsp.digest_index = index;
   assign rsp.digest_last  = (index == IndexWidth'(DigestWords - 1));
endmodule
`default_nettype wire

@@ hw/rtl/sha256_datapath.sv @@
// Datapath of the hasher: block buffer, message schedule, round unit,
// chain value and length counter. Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sha256_pkg::dp_cmd_type           cmd,
   output sha256_pkg::dp_status_type             status,
   input  wire sha256_pkg::word_type             in_word,
   input  wire logic [sha256_pkg::CountWidth-1:0] in_count,
   input  wire logic                             in_last,
   output sha256_pkg::word_type                  digest_word
);
   import sha256_pkg::*;

   word_type   sched_ff [BlockWords];
   word_type   chain_ff [DigestWords];
   word_type   chain_in [DigestWords];
   word_type   work_ff  [DigestWords];
   word_type   work_in  [DigestWords];
   logic [3:0] pos_ff, pos_in;
   logic [5:0] round_ff, round_in;
   logic [63:0] len_ff, len_in;
   logic [2:0] sat_count;
   word_type   fill_word;
   word_type   mask;
   word_type   w_new, t1, t2;
   logic       write_en;

   // Saturate the byte count and mask off bytes that are not valid.
   always_comb begin
      sat_count = (!in_last || in_count > 3'd4) ? 3'd4 : in_count;
      case (sat_count)
         3'd0: mask = 32'h0000_0000;
         3'd1: mask = 32'hff00_0000;
         3'd2: mask = 32'hffff_0000;
         3'd3: mask = 32'hffff_ff00;
         default: mask = 32'hffff_ffff;
      endcase
   end

   // Word entering the buffer: input word (with the marker byte on a short tail)
   // or a padding word.
   always_comb begin
      fill_word = '0;
      if (cmd.load_word) begin
         case (sat_count)
            3'd0: fill_word = 32'h8000_0000;
            3'd1: fill_word = (in_word & mask) | 32'h0080_0000;
            3'd2: fill_word = (in_word & mask) | 32'h0000_8000;
            3'd3: fill_word = (in_word & mask) | 32'h0000_0080;
            default: fill_word = in_word;
         endcase
      end else begin
         case (cmd.pad_kind)
            PadMark:  fill_word = 32'h8000_0000;
            PadLenHi: fill_word = len_ff[63:32];
            PadLenLo: fill_word = len_ff[31:0];
            default:  fill_word = '0;
         endcase
      end
   end

   assign write_en = cmd.load_word || cmd.push_pad;

   // Length counter and buffer position.
   always_comb begin
      len_in = len_ff;
      pos_in = pos_ff;
      if (cmd.load_word) begin
         len_in = len_ff + {58'd0, sat_count, 3'd0};
      end
      if (write_en) begin
         pos_in = pos_ff + 4'd1;
      end
      if (cmd.reinit) begin
         len_in = '0;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         pos_ff <= '0;
      end else begin
         len_ff <= len_in;
         pos_ff <= pos_in;
      end
   end

   // The buffer doubles as a sliding schedule window: words enter at the top
   // and each round shifts in the next schedule word.
   assign w_new = sched_ff[0] + small_sigma0(sched_ff[1]) + sched_ff[9]
                + small_sigma1(sched_ff[14]);

   always_ff @(posedge clock) begin
      if (write_en || cmd.round) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[BlockWords-1] <= write_en ? fill_word : w_new;
      end
   end

   // One compression round per cycle.
   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + RoundK[round_ff] + sched_ff[0];
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));

   always_comb begin
      work_in  = work_ff;
      round_in = round_ff;
      if (cmd.start_block) begin
         work_in  = chain_ff;
         round_in = '0;
      end else if (cmd.round) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
         round_in   = round_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      round_ff <= round_in;
   end

   // Chain value: add at block end, rotate for output, reload after digest.
   always_comb begin
      chain_in = chain_ff;
      if (cmd.finish_block) begin
         for (int i = 0; i < DigestWords; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end else if (cmd.shift_digest) begin
         for (int i = 0; i < DigestWords - 1; i++) begin
            chain_in[i] = chain_ff[i+1];
         end
         chain_in[DigestWords-1] = chain_ff[0];
      end
      if (cmd.reinit) begin
         chain_in = InitHash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= InitHash;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign digest_word       = chain_ff[0];
   assign status.block_full = (pos_ff == 4'd0);
   assign status.position   = pos_ff;
   assign status.last_round = (round_ff == 6'(Rounds - 1));
endmodule
`default_nettype wire

@@ hw/rtl/sha256_controller.sv @@
// Controller state machine of the hasher: sequences word transfers, padding,
// compression rounds and digest output. Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_controller (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [sha256_pkg::CountWidth-1:0]  req_count,
   input  wire logic                               req_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [sha256_pkg::IndexWidth-1:0]       rsp_index,
   output sha256_pkg::dp_cmd_type                  cmd,
   input  wire sha256_pkg::dp_status_type          status
);
   import sha256_pkg::*;

   typedef enum logic [6:0] {
      StIdle   = 7'b0000001,
      StStart  = 7'b0000010,
      StRound  = 7'b0000100,
      StFinish = 7'b0001000,
      StPad    = 7'b0010000,
      StOut    = 7'b0100000,
      StReinit = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      final_ff, final_in;  // Message tail being padded.
   logic      mark_ff, mark_in;    // Marker byte still owed.
   logic      lenhi_ff, lenhi_in;  // Upper length word sits in this block.
   logic      done_ff, done_in;    // Length words are in the buffer.
   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic      take;

   assign req_ready = (state_ff == StIdle);
   assign take      = req_valid && req_ready;
   assign rsp_valid = (state_ff == StOut);
   assign rsp_index = idx_ff;

   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      mark_in  = mark_ff;
      lenhi_in = lenhi_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (take) begin
               cmd.load_word = 1'b1;
               if (req_last) begin
                  final_in = 1'b1;
                  mark_in  = (req_count >= 3'd4);
               end
               if (status.position == 4'd15) begin
                  state_in = StStart;
               end else if (req_last) begin
                  state_in = StPad;
               end
            end
         end
         StPad: begin
            // Marker word, zero fill, then length in the last two slots.
            // A block whose slot 14 went to data or the marker is zero filled
            // and the length moves to the next block.
            cmd.push_pad = 1'b1;
            if (mark_ff) begin
               cmd.pad_kind = PadMark;
               mark_in = 1'b0;
            end else if (status.position == 4'd14) begin
               cmd.pad_kind = PadLenHi;
               lenhi_in = 1'b1;
            end else if (status.position == 4'd15 && lenhi_ff) begin
               cmd.pad_kind = PadLenLo;
               final_in = 1'b0;
               lenhi_in = 1'b0;
            end else begin
               cmd.pad_kind = PadZero;
            end
            if (status.position == 4'd15) begin
               state_in = StStart;
            end
         end
         StStart: begin
            cmd.start_block = 1'b1;
            state_in = StRound;
         end
         StRound: begin
            cmd.round = 1'b1;
            if (status.last_round) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            cmd.finish_block = 1'b1;
            if (final_ff) begin
               state_in = StPad;
            end else if (mark_ff || status.block_full == 1'b0) begin
               state_in = StIdle;
            end else begin
               state_in = StIdle;
            end
         end
         StOut: begin
            if (rsp_ready) begin
               cmd.shift_digest = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == IndexWidth'(DigestWords - 1)) begin
                  state_in = StReinit;
               end
            end
         end
         StReinit: begin
            cmd.reinit = 1'b1;
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
      // A block that closed the message (length written) leads to output.
      if (state_ff == StFinish && !final_ff && done_ff) begin
         state_in = StOut;
      end
   end

   // Set once the length words are in, so the next block end gives the digest.
   always_comb begin
      done_in = done_ff;
      if (state_ff == StPad && status.position == 4'd15 && lenhi_ff) begin
         done_in = 1'b1;
      end
      if (state_ff == StReinit) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         final_ff <= 1'b0;
         mark_ff  <= 1'b0;
         lenhi_ff <= 1'b0;
         done_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         mark_ff  <= mark_in;
         lenhi_ff <= lenhi_in;
         done_ff  <= done_in;
         idx_ff   <= idx_in;
      end
   end
endmodule
`default_nettype wire

@@ test/sha256_stream_hasher_core_test.sv @@
// Self-checking testbench of the streaming SHA-256 hasher core.
// Predicts each digest with an internal hash model and checks every digest word.
// Depends on sha256_pkg, sha256_req_if, sha256_rsp_if and sha256_stream_hasher_core.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_core_test;
   import sha256_pkg::*;

   typedef struct packed {
      word_type              digest_word;
      logic [IndexWidth-1:0] digest_index;
      logic                  digest_last;
   } digest_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha256_req_if req ();
   sha256_rsp_if rsp ();

   sha256_stream_hasher_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // Model state of the hasher.
   word_type        chain_model [DigestWords];
   word_type        block_model [BlockWords];
   int unsigned     fill_model;
   logic [63:0]     length_model;
   digest_item_type expected_digests [$];
   int              error_count = 0;
   int              burst_left = 0;
   int              hold_off_cycles = 0;
   logic            stall_pattern_on = 1'b1;

   initial begin
      forever #2 clock = ~clock;
   end

   // Round helpers written directly from the standard.
   function automatic word_type ror32(input word_type x, input int n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_model();
      word_type w [Rounds];
      word_type a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = block_model[i];
      for (int i = 16; i < 64; i++) begin
         w[i] = w[i-16] + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      a = chain_model[0]; b = chain_model[1]; c = chain_model[2]; d = chain_model[3];
      e = chain_model[4]; f = chain_model[5]; g = chain_model[6]; h = chain_model[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + RoundK[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_model[0] += a; chain_model[1] += b; chain_model[2] += c; chain_model[3] += d;
      chain_model[4] += e; chain_model[5] += f; chain_model[6] += g; chain_model[7] += h;
   endtask

   task automatic buffer_word(input word_type w);
      block_model[fill_model] = w;
      fill_model = (fill_model + 1) % 16;
      if (fill_model == 0) compress_model();
   endtask

   task automatic restart_model();
      for (int i = 0; i < DigestWords; i++) chain_model[i] = InitHash[i];
      fill_model = 0;
      length_model = '0;
   endtask

   // Updates the model with one accepted word and queues any digest it completes.
   task automatic predict_digest(input word_type data, input logic [2:0] count,
                                 input logic last);
      int unsigned bytes;
      word_type mask;
      digest_item_type item;
      if (!last) begin
         length_model += 64'd32;
         buffer_word(data);
      end else begin
         bytes = (count > 4) ? 4 : count;
         length_model += 64'(8 * bytes);
         if (bytes == 4) begin
            buffer_word(data);
            buffer_word(32'h8000_0000);
         end else begin
            mask = (bytes == 0) ? '0 : (32'hffff_ffff << (32 - 8 * bytes));
            buffer_word((data & mask) | (32'h80 << (24 - 8 * bytes)));
         end
         while (fill_model != 14) buffer_word('0);
         buffer_word(length_model[63:32]);
         buffer_word(length_model[31:0]);
         for (int i = 0; i < DigestWords; i++) begin
            item.digest_word  = chain_model[i];
            item.digest_index = IndexWidth'(i);
            item.digest_last  = (i == DigestWords - 1);
            expected_digests.push_back(item);
         end
         restart_model();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("mismatch: %s got %h expected %h", what, seen, wanted);
      error_count++;
   endtask

   // Sends one word; the sender drops valid and pauses at random between bursts,
   // and within a burst the next word follows the previous transfer directly.
   task automatic send_word(input word_type data, input logic [2:0] count,
                            input logic last);
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req.valid      <= 1'b1;
      req.data_word  <= data;
      req.byte_count <= count;
      req.last_word  <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_digest(data, count, last);
      burst_left--;
   endtask

   task automatic send_message(input int words, input logic [2:0] tail_count);
      for (int i = 0; i < words - 1; i++) send_word($urandom, 3'($urandom), 1'b0);
      send_word($urandom, tail_count, 1'b1);
   endtask

   // Receiver readiness: long hold-off when asked, else a random stall pattern, or always ready with the pattern off.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= stall_pattern_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   // Checks each digest transfer against the oldest expected word.
   always @(posedge clock) begin
      digest_item_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_digests.size() == 0) begin
            report_mismatch("unexpected digest word", rsp.digest_word, '0);
         end else begin
            want = expected_digests.pop_front();
            if (rsp.digest_word !== want.digest_word)
               report_mismatch("digest_word", rsp.digest_word, want.digest_word);
            if (rsp.digest_index !== want.digest_index)
               report_mismatch("digest_index", 32'(rsp.digest_index),
                               32'(want.digest_index));
            if (rsp.digest_last !== want.digest_last)
               report_mismatch("digest_last", 32'(rsp.digest_last),
                               32'(want.digest_last));
         end
      end
   end

   // Known messages and field extremes, one message for each special case.
   task automatic test_directed();
      send_word(32'h6162_63ff, 3'd3, 1'b1);              // "abc", junk byte cleared
      send_word(32'h0000_0000, 3'd0, 1'b1);              // empty message
      send_word(32'hffff_ffff, 3'd7, 1'b1);              // count above four saturates
      send_word(32'hffff_ffff, 3'd4, 1'b1);
      send_word(32'h1234_5678, 3'd1, 1'b1);
      send_word(32'h1234_5678, 3'd2, 1'b1);
      send_word(32'hffff_ffff, 3'd5, 1'b0);              // count above four on a non-last word
      send_word(32'h0000_0000, 3'd6, 1'b1);
      send_message(16, 3'd0);                            // sixteen words, the last carrying only the marker
      send_message(14, 3'd4);                            // padding spills into a second block
   endtask

   // Random messages, mostly short, some spanning several blocks.
   task automatic test_random_messages();
      int sent = 0;
      int words;
      while (sent < 50) begin
         words = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 40) : $urandom_range(1, 6);
         send_message(words, 3'($urandom));
         sent += words;
      end
   endtask

   // Receiver holds off as the sender keeps offering so the block backs up; always ready as a last message is sent.
   task automatic test_receiver_hold_off();
      hold_off_cycles = 400;
      send_message(3, 3'd2);
      send_message(17, 3'd4);
      send_message(2, 3'd1);
      stall_pattern_on = 1'b0;
      send_message(20, 3'd3);
      stall_pattern_on = 1'b1;
   endtask

   initial begin
      req.valid      <= 1'b0;
      req.data_word  <= '0;
      req.byte_count <= '0;
      req.last_word  <= 1'b0;
      restart_model();
      for (int i = 0; i < BlockWords; i++) block_model[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_messages();
      test_receiver_hold_off();
      req.valid <= 1'b0;
      while (expected_digests.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_digests.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
